>>> hdl/sgb_pkg.sv
package sgb_pkg;

  // Fixed sizes of the data path.
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 17;
  localparam int COEF_FRAC  = 16;
  localparam int HSUM_W     = COEF_FRAC + 10;
  localparam int MAX_RADIUS = 4;
  localparam int NUM_COEF   = MAX_RADIUS + 1;
  localparam int WIN        = 2 * MAX_RADIUS + 1;
  localparam int SLOT_W     = $clog2(WIN);
  localparam int DIM_W      = 12;
  localparam int HGT_W      = 13;
  localparam int RAD_W      = 3;
  localparam int CNT_W      = 24;
  localparam int MAX_HEIGHT = 4096;

  localparam int PAIR_W  = PIX_W + 1;
  localparam int HPROD_W = PAIR_W + COEF_W;
  localparam int HACC_W  = HPROD_W + 3;
  localparam int VPAIR_W = HSUM_W + 1;
  localparam int VPROD_W = VPAIR_W + COEF_W;
  localparam int VACC_W  = VPROD_W + 3;
  localparam int RND_SH  = 2 * COEF_FRAC;

  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;
  localparam int RST_RADIUS = 2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_COEF_CENTER  = 3'd3,
    REG_COEF_1       = 3'd4,
    REG_COEF_2       = 3'd5,
    REG_COEF_3       = 3'd6,
    REG_COEF_4       = 3'd7
  } cfg_reg_e;

  // Frame geometry after clamping, with the derived item counts.
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [HGT_W-1:0] h;
    logic [RAD_W-1:0] r;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] lag;
  } geom_t;

  localparam geom_t GEOM_RST = '{
    w:     DIM_W'(RST_WIDTH),
    h:     HGT_W'(RST_HEIGHT),
    r:     RAD_W'(RST_RADIUS),
    total: CNT_W'(RST_WIDTH * RST_HEIGHT),
    lag:   CNT_W'(RST_RADIUS * RST_WIDTH + RST_RADIUS)
  };

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_t;

  // Control for the vertical pass of one output pixel.
  typedef struct packed {
    logic                              emit;
    logic                              last;
    logic [DIM_W-1:0]                  col;
    logic [NUM_COEF-1:0][SLOT_W-1:0]   bank_p;
    logic [NUM_COEF-1:0][SLOT_W-1:0]   bank_m;
    logic [NUM_COEF-1:0]               tap_en;
  } vctl_t;

  // One operation of the horizontal pass.
  typedef struct packed {
    logic                              we;
    logic [SLOT_W-1:0]                 slot;
    logic [DIM_W-1:0]                  col;
    logic [NUM_COEF-1:0][PAIR_W-1:0]   pair;
    vctl_t                             v;
  } hop_t;

  // One line store write, with the vertical control riding along.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [DIM_W-1:0]  col;
    logic [HSUM_W-1:0] hsum;
    vctl_t             v;
  } wr_t;

endpackage

>>> hdl/sgb_front.sv
module sgb_front import sgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [PIX_W-1:0] pixel_in_i,
  input  logic             credit_ok_i,
  input  geom_t            geom_i,
  output logic             emit_o,
  output hop_t             op_o
);

  localparam int IDX_W = $clog2(WIN);

  logic [DIM_W-1:0]  in_col_q, in_row_q, ocol_q, orow_q;
  logic [SLOT_W-1:0] in_slot_q, oslot_q;
  logic [CNT_W-1:0]  in_cnt_q, out_cnt_q;
  logic              burst_q;
  logic [DIM_W-1:0]  bcol_q, bend_q;
  logic [SLOT_W-1:0] bslot_q;
  logic [PIX_W-1:0]  win_q [WIN];
  logic [PIX_W-1:0]  win_d [WIN];
  hop_t              op_q, op_d;

  logic acc, in_done, pix_take, drn_take, take, emit, last, row_end, j_ge_r;
  logic [DIM_W-1:0] lo, cur_c, cur_j;

  function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] s, logic [RAD_W-1:0] x);
    logic [SLOT_W-1:0] sum;
    sum = s + SLOT_W'(x);
    return (sum >= SLOT_W'(WIN)) ? sum - SLOT_W'(WIN) : sum;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_sub(logic [SLOT_W-1:0] s, logic [RAD_W-1:0] x);
    return (s >= SLOT_W'(x)) ? s - SLOT_W'(x) : s + SLOT_W'(WIN) - SLOT_W'(x);
  endfunction

  assign in_ready_o = !burst_q && credit_ok_i;
  assign acc        = in_valid_i && in_ready_o;
  assign in_done    = in_cnt_q >= geom_i.total;
  assign pix_take   = acc && (cmd_i == CMD_PIXEL) && !in_done;
  assign drn_take   = acc && (cmd_i == CMD_DRAIN) && in_done;
  assign take       = pix_take || drn_take;
  assign emit       = take && (in_cnt_q >= geom_i.lag) && (out_cnt_q < geom_i.total);
  assign last       = emit && (CNT_W'(out_cnt_q + 1'b1) == geom_i.total);
  assign row_end    = ({1'b0, in_col_q} + 1'b1) >= {1'b0, geom_i.w};
  assign j_ge_r     = in_col_q >= DIM_W'(geom_i.r);
  assign lo         = j_ge_r ? in_col_q - DIM_W'(geom_i.r) : '0;
  assign cur_c      = burst_q ? bcol_q : lo;
  assign cur_j      = burst_q ? bend_q : in_col_q;
  assign emit_o     = emit;
  assign op_o       = op_q;

  // Recent pixels of the current row, newest at index zero.
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      if (!pix_take) begin
        win_d[i] = win_q[i];
      end else if (i == 0) begin
        win_d[i] = pixel_in_i;
      end else begin
        win_d[i] = win_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < WIN; i++) begin
      win_q[i] <= win_d[i];
    end
  end

  always_comb begin
    logic [DIM_W-1:0]  diff;
    logic [RAD_W-1:0]  e, down, up, dp, dm;
    logic [IDX_W-1:0]  kp, km, em;
    logic [HGT_W-1:0]  rem;
    op_d = '0;
    diff = cur_j - cur_c;
    e    = diff[RAD_W-1:0];
    op_d.we   = burst_q || (pix_take && (row_end || j_ge_r));
    op_d.slot = burst_q ? bslot_q : in_slot_q;
    op_d.col  = cur_c;
    // Edge pixels repeat: taps left of column zero or right of the newest pixel clamp.
    for (int d = 0; d < NUM_COEF; d++) begin
      kp = (e > RAD_W'(d)) ? IDX_W'(e - RAD_W'(d)) : '0;
      em = IDX_W'(e) + IDX_W'(d);
      km = ({{(DIM_W-IDX_W){1'b0}}, em} > cur_j) ? cur_j[IDX_W-1:0] : em;
      if (d == 0) begin
        op_d.pair[d] = {1'b0, win_d[IDX_W'(e)]};
      end else if (RAD_W'(d) <= geom_i.r) begin
        op_d.pair[d] = PAIR_W'(win_d[kp]) + PAIR_W'(win_d[km]);
      end else begin
        op_d.pair[d] = '0;
      end
    end
    // Row slots of the vertical taps, clamped to the first and last row.
    down = (orow_q >= DIM_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : orow_q[RAD_W-1:0];
    rem  = geom_i.h - 1'b1 - {1'b0, orow_q};
    up   = (rem >= HGT_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rem[RAD_W-1:0];
    for (int d = 0; d < NUM_COEF; d++) begin
      dp = (RAD_W'(d) < up) ? RAD_W'(d) : up;
      dm = (RAD_W'(d) < down) ? RAD_W'(d) : down;
      op_d.v.bank_p[d] = slot_add(oslot_q, dp);
      op_d.v.bank_m[d] = slot_sub(oslot_q, dm);
      op_d.v.tap_en[d] = RAD_W'(d) <= geom_i.r;
    end
    op_d.v.emit = emit;
    op_d.v.last = last;
    op_d.v.col  = ocol_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= '0;
      burst_q   <= 1'b0;
      bcol_q    <= '0;
      bend_q    <= '0;
      bslot_q   <= '0;
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_slot_q <= '0;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      ocol_q    <= '0;
      orow_q    <= '0;
      oslot_q   <= '0;
    end else begin
      op_q <= op_d;
      if (burst_q) begin
        if (bcol_q == bend_q) begin
          burst_q <= 1'b0;
        end else begin
          bcol_q <= bcol_q + 1'b1;
        end
      end else if (pix_take && row_end && (lo != in_col_q)) begin
        burst_q <= 1'b1;
        bcol_q  <= lo + 1'b1;
        bend_q  <= in_col_q;
        bslot_q <= in_slot_q;
      end
      if (pix_take) begin
        if (row_end) begin
          in_col_q <= '0;
          if (({1'b0, in_row_q} + 1'b1) >= geom_i.h) begin
            in_row_q  <= '0;
            in_slot_q <= '0;
          end else begin
            in_row_q  <= in_row_q + 1'b1;
            in_slot_q <= slot_add(in_slot_q, RAD_W'(1));
          end
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (take) begin
        in_cnt_q <= in_cnt_q + 1'b1;
      end
      if (emit) begin
        out_cnt_q <= out_cnt_q + 1'b1;
        if ((ocol_q + 1'b1) == geom_i.w) begin
          ocol_q  <= '0;
          orow_q  <= orow_q + 1'b1;
          oslot_q <= slot_add(oslot_q, RAD_W'(1));
        end else begin
          ocol_q <= ocol_q + 1'b1;
        end
      end
      if (last) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        in_slot_q <= '0;
        in_cnt_q  <= '0;
        out_cnt_q <= '0;
        ocol_q    <= '0;
        orow_q    <= '0;
        oslot_q   <= '0;
      end
    end
  end

endmodule

>>> hdl/sgb_hfilt.sv
module sgb_hfilt import sgb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  hop_t  op_i,
  input  coef_t coef_i,
  output wr_t   wr_o
);

  localparam logic [HACC_W-1:0] HSUM_MAX = HACC_W'((64'd1 << HSUM_W) - 64'd1);

  logic [NUM_COEF-1:0][HPROD_W-1:0] prod_q;
  logic              s1_we_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic [DIM_W-1:0]  s1_col_q;
  vctl_t             s1_v_q;
  wr_t               wr_q, wr_d;

  // Symmetric taps were already paired, so one product per distance.
  always_ff @(posedge clk_i) begin
    for (int d = 0; d < NUM_COEF; d++) begin
      prod_q[d] <= op_i.pair[d] * coef_i[d];
    end
    s1_slot_q <= op_i.slot;
    s1_col_q  <= op_i.col;
  end

  always_comb begin
    logic [HACC_W-1:0] acc;
    acc = '0;
    for (int d = 0; d < NUM_COEF; d++) begin
      acc = acc + HACC_W'(prod_q[d]);
    end
    wr_d.we   = s1_we_q;
    wr_d.slot = s1_slot_q;
    wr_d.col  = s1_col_q;
    wr_d.hsum = (acc > HSUM_MAX) ? HSUM_MAX[HSUM_W-1:0] : acc[HSUM_W-1:0];
    wr_d.v    = s1_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_we_q <= 1'b0;
      s1_v_q  <= '0;
      wr_q    <= '0;
    end else begin
      s1_we_q <= op_i.we;
      s1_v_q  <= op_i.v;
      wr_q    <= wr_d;
    end
  end

  assign wr_o = wr_q;

endmodule

>>> hdl/sgb_line_store.sv
module sgb_line_store import sgb_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wr_t                           wr_i,
  output logic [WIN-1:0][HSUM_W-1:0]    rd_o,
  output vctl_t                         v_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  vctl_t            rd_v_q, out_v_q;
  logic [HSUM_W-1:0] rd_q [WIN];

  // One bank per row slot; all banks read the same column at once.
  for (genvar b = 0; b < WIN; b++) begin : g_bank
    logic [HSUM_W-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (wr_i.we && (wr_i.slot == SLOT_W'(b))) begin
        mem[AW'(wr_i.col)] <= wr_i.hsum;
      end
      if (rd_v_q.emit) begin
        rd_q[b] <= mem[AW'(rd_v_q.col)];
      end
    end
  end

  // The read happens in the cycle after the write of the same operation, so that it
  // sees the column just written; a write in the same cycle returns old data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= '0;
      out_v_q <= '0;
    end else begin
      rd_v_q  <= wr_i.v;
      out_v_q <= rd_v_q;
    end
  end

  always_comb begin
    for (int b = 0; b < WIN; b++) begin
      rd_o[b] = rd_q[b];
    end
  end

  assign v_o = out_v_q;

endmodule

>>> hdl/sgb_vfilt.sv
module sgb_vfilt import sgb_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [WIN-1:0][HSUM_W-1:0] rd_i,
  input  vctl_t                      v_i,
  input  coef_t                      coef_i,
  output logic                       push_o,
  output logic [PIX_W-1:0]           pixel_o,
  output logic                       last_o
);

  localparam logic [VACC_W-1:0] HALF = VACC_W'(1) << (RND_SH - 1);
  localparam int                Q_W  = VACC_W - RND_SH;

  logic [NUM_COEF-1:0][VPAIR_W-1:0] vp_q;
  logic [NUM_COEF-1:0][VPROD_W-1:0] prod_q;
  logic             s1_emit_q, s1_last_q, s2_emit_q, s2_last_q;
  logic             push_q, last_q;
  logic [PIX_W-1:0] pix_q, pix_d;

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < NUM_COEF; d++) begin
      if (!v_i.tap_en[d]) begin
        vp_q[d] <= '0;
      end else if (d == 0) begin
        vp_q[d] <= VPAIR_W'(rd_i[v_i.bank_p[d]]);
      end else begin
        vp_q[d] <= VPAIR_W'(rd_i[v_i.bank_p[d]]) + VPAIR_W'(rd_i[v_i.bank_m[d]]);
      end
      prod_q[d] <= VPROD_W'(vp_q[d]) * VPROD_W'(coef_i[d]);
    end
    pix_q <= pix_d;
  end

  // Round half up, then saturate to the pixel range.
  always_comb begin
    logic [VACC_W-1:0] acc;
    logic [Q_W-1:0]    q;
    acc = HALF;
    for (int d = 0; d < NUM_COEF; d++) begin
      acc = acc + VACC_W'(prod_q[d]);
    end
    q     = acc[VACC_W-1:RND_SH];
    pix_d = (q > Q_W'(255)) ? 8'hFF : q[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_emit_q <= 1'b0;
      s1_last_q <= 1'b0;
      s2_emit_q <= 1'b0;
      s2_last_q <= 1'b0;
      push_q    <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      s1_emit_q <= v_i.emit;
      s1_last_q <= v_i.last;
      s2_emit_q <= s1_emit_q;
      s2_last_q <= s1_last_q;
      push_q    <= s2_emit_q;
      last_q    <= s2_last_q;
    end
  end

  assign push_o  = push_q;
  assign pixel_o = pix_q;
  assign last_o  = last_q;

endmodule

>>> hdl/separable_gaussian_blur_unit.sv
// Separable Gaussian blur with replicated borders for 8-bit grayscale pixels
// in raster order. Each pixel is filtered horizontally with the programmed
// Q1.16 weights, and the unrounded 26-bit row sums go into a line store of
// nine banks, one per row slot, each MAX_WIDTH deep. Every output reads the
// same column from all nine banks at once and forms the vertical sum,
// rounded half up and saturated to 255. The block takes one item per clock
// while the output queue has a free credit. The pixel that ends a row is the
// exception: after it the input is held while the row's remaining columns, up
// to radius+1 of them, are written one per cycle through the single write
// port of the line store. Output item k is started when input item
// k+radius*width+radius is accepted; send cmd=1 drain items after the frame
// to flush the last outputs. A small output queue with credit tracking lets
// input go on while results wait. The line store needs no clearing after
// reset. Configuration writes are taken in any cycle. The weights apply from
// the next cycle on, and the frame size and radius once the clamped geometry
// register has taken them. Change them only while no frame is in progress.
module separable_gaussian_blur_unit import sgb_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [PIX_W-1:0]  pixel_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PIX_W-1:0]  pixel_out_o,
  output logic              frame_last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [COEF_W-1:0] cfg_data_i
);

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Configuration registers.
  logic [DIM_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic [RAD_W-1:0] radius_q;
  coef_t            coef_q;
  geom_t            geom_q, geom_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_W'(RST_WIDTH);
      height_q  <= HGT_W'(RST_HEIGHT);
      radius_q  <= RAD_W'(RST_RADIUS);
      coef_q[0] <= COEF_W'(26386);
      coef_q[1] <= COEF_W'(16004);
      coef_q[2] <= COEF_W'(3571);
      coef_q[3] <= '0;
      coef_q[4] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q   <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_q  <= cfg_data_i[HGT_W-1:0];
        REG_RADIUS:       radius_q  <= cfg_data_i[RAD_W-1:0];
        REG_COEF_CENTER:  coef_q[0] <= cfg_data_i;
        REG_COEF_1:       coef_q[1] <= cfg_data_i;
        REG_COEF_2:       coef_q[2] <= cfg_data_i;
        REG_COEF_3:       coef_q[3] <= cfg_data_i;
        REG_COEF_4:       coef_q[4] <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Clamped geometry and frame counts, registered so the frame counters
  // compare against stable values.
  always_comb begin
    if (width_q == '0) begin
      geom_d.w = DIM_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      geom_d.w = DIM_W'(MAX_WIDTH);
    end else begin
      geom_d.w = width_q;
    end
    if (height_q == '0) begin
      geom_d.h = HGT_W'(1);
    end else if (height_q > HGT_W'(MAX_HEIGHT)) begin
      geom_d.h = HGT_W'(MAX_HEIGHT);
    end else begin
      geom_d.h = height_q;
    end
    geom_d.r     = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
    geom_d.total = CNT_W'(geom_d.w * geom_d.h);
    geom_d.lag   = CNT_W'(geom_d.r * geom_d.w) + CNT_W'(geom_d.r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q <= GEOM_RST;
    end else begin
      geom_q <= geom_d;
    end
  end

  // Data path.
  logic             credit_ok, emit;
  hop_t             op;
  wr_t              wr;
  logic [WIN-1:0][HSUM_W-1:0] rd;
  vctl_t            rd_v;
  logic             push, push_last;
  logic [PIX_W-1:0] push_pix;

  sgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .pixel_in_i  (pixel_in_i),
    .credit_ok_i (credit_ok),
    .geom_i      (geom_q),
    .emit_o      (emit),
    .op_o        (op)
  );

  sgb_hfilt u_hfilt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .coef_i (coef_q),
    .wr_o   (wr)
  );

  sgb_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .rd_o   (rd),
    .v_o    (rd_v)
  );

  sgb_vfilt u_vfilt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd),
    .v_i     (rd_v),
    .coef_i  (coef_q),
    .push_o  (push),
    .pixel_o (push_pix),
    .last_o  (push_last)
  );

  // Output queue. Each accepted item that will produce a result reserves a
  // slot, so the queue can never overflow while the pipeline runs freely.
  logic [PIX_W:0]    fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] fifo_cnt_q, res_q;
  logic              pop;

  assign pop          = out_valid_o && out_ready_i;
  assign out_valid_o  = fifo_cnt_q != '0;
  assign pixel_out_o  = fifo_q[rd_ptr_q][PIX_W-1:0];
  assign frame_last_o = fifo_q[rd_ptr_q][PIX_W];
  assign credit_ok    = res_q < FCNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {push_last, push_pix};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      res_q      <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fifo_cnt_q <= fifo_cnt_q + FCNT_W'(push) - FCNT_W'(pop);
      res_q      <= res_q + FCNT_W'(emit) - FCNT_W'(pop);
    end
  end

  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q < FCNT_W'(FIFO_DEPTH)))
    else $error("output queue written while full");

  a_credit_covers_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= res_q)
    else $error("queued results exceed reserved credits");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q <= FCNT_W'(FIFO_DEPTH))
    else $error("reserved credits exceed queue depth");

endmodule

>>> tb/sv/tb_separable_gaussian_blur_unit.sv
module tb_separable_gaussian_blur_unit;
  import sgb_pkg::*;

  localparam int STORE_COLS = 2048;
  localparam int STALL_LIMIT = 5000;

  // Tracks the blur state of the block and holds the output pixels that are still
  // due. Every accepted input is run through the same arithmetic as the block, and
  // every output transfer is matched against the oldest pending pixel.
  class blur_scoreboard;
    int unsigned width_reg, height_reg, radius_reg;
    int unsigned weights[NUM_COEF];
    int unsigned row_sums[WIN * STORE_COLS];
    int unsigned recent_pix[WIN];
    int unsigned in_cnt, out_cnt, in_row, in_col;
    logic [PIX_W:0] due_pixels[$];
    int errors;

    function new();
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      radius_reg = RST_RADIUS;
      weights = '{26386, 16004, 3571, 0, 0};
      foreach (row_sums[i]) row_sums[i] = 0;
      foreach (recent_pix[i]) recent_pix[i] = 0;
      in_cnt = 0; out_cnt = 0; in_row = 0; in_col = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, int unsigned value);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = value & 32'hFFF;
        REG_IMAGE_HEIGHT: height_reg = value & 32'h1FFF;
        REG_RADIUS:       radius_reg = value & 32'h7;
        default:          weights[int'(idx) - int'(REG_COEF_CENTER)] = value & 32'h1FFFF;
      endcase
    endfunction

    // Frame geometry after the same clamping that the block applies.
    function void geometry(output int unsigned w, output int unsigned h,
                           output int unsigned r, output int unsigned total,
                           output int unsigned lag);
      w = (width_reg < 1) ? 1 : (width_reg > STORE_COLS ? STORE_COLS : width_reg);
      h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
      r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
      total = w * h;
      lag = r * w + r;
    endfunction

    // Unrounded horizontal sum at one column, with pixels past the right-most
    // one seen so far replaced by it.
    function int unsigned row_sum_at(int col, int right, int r);
      longint unsigned acc;
      int x;
      acc = 0;
      for (int d = -r; d <= r; d++) begin
        x = col + d;
        if (x < 0) x = 0;
        if (x > right) x = right;
        acc += longint'(weights[d < 0 ? -d : d]) * recent_pix[x % WIN];
      end
      if (acc > (64'd1 << HSUM_W) - 1) acc = (64'd1 << HSUM_W) - 1;
      return int'(acc);
    endfunction

    function void note_item(logic cmd, logic [PIX_W-1:0] pix);
      int unsigned w, h, r, total, lag, k, p, orow, ocol;
      int lo, hi, y;
      bit row_end;
      longint unsigned acc, v;
      geometry(w, h, r, total, lag);
      if (out_cnt >= total) begin
        in_cnt = 0; out_cnt = 0; in_row = 0; in_col = 0;
      end
      k = in_cnt;
      if (cmd == CMD_PIXEL) begin
        if (k >= total) return;
        recent_pix[in_col % WIN] = pix;
        row_end = (in_col + 1 >= w);
        if (row_end) begin
          lo = (in_col >= r) ? int'(in_col - r) : 0;
          hi = in_col;
        end else begin
          lo = int'(in_col) - int'(r);
          hi = lo;
        end
        if (row_end || in_col >= r)
          for (int c = lo; c <= hi; c++)
            row_sums[(in_row % WIN) * STORE_COLS + c] = row_sum_at(c, in_col, r);
        if (row_end) begin
          in_col = 0;
          in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
        end else begin
          in_col++;
        end
      end else if (k < total) begin
        return;
      end
      in_cnt = k + 1;
      if (k >= lag && out_cnt < total) begin
        p = out_cnt;
        orow = p / w;
        ocol = p % w;
        acc = 0;
        for (int d = -int'(r); d <= int'(r); d++) begin
          y = int'(orow) + d;
          if (y < 0) y = 0;
          if (y > int'(h) - 1) y = h - 1;
          acc += longint'(weights[d < 0 ? -d : d]) *
                 row_sums[(y % WIN) * STORE_COLS + ocol];
        end
        v = (acc + (64'd1 << (RND_SH - 1))) >> RND_SH;
        if (v > 255) v = 255;
        out_cnt = p + 1;
        due_pixels.push_back({out_cnt == total, v[PIX_W-1:0]});
        if (out_cnt == total) begin
          in_cnt = 0; out_cnt = 0; in_row = 0; in_col = 0;
        end
      end
    endfunction

    function void check_pixel(logic [PIX_W-1:0] pix, logic last);
      logic [PIX_W:0] want;
      if (due_pixels.size() == 0) begin
        $display("%0t: unexpected output pixel %0d last %0b", $time, pix, last);
        errors++;
        return;
      end
      want = due_pixels.pop_front();
      if (pix !== want[PIX_W-1:0]) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, want[PIX_W-1:0], pix);
        errors++;
      end
      if (last !== want[PIX_W]) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, want[PIX_W], last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              cmd_i = CMD_PIXEL;
  logic [PIX_W-1:0]  pixel_in_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PIX_W-1:0]  pixel_out_o;
  logic              frame_last_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;

  separable_gaussian_blur_unit dut (.*);

  blur_scoreboard sb = new();
  bit calm = 1'b0;      // Set while neither side is allowed to idle.
  int stalled = 0;
  int sent_items = 0;   // Input transfers so far, pixels and drains alike.

  always #5 clk_i = ~clk_i;

  // The receiver holds back output transfers at random, with a chance of 18 percent, unless calm is set.
  always @(negedge clk_i)
    out_ready_i <= rst_ni && (calm || $urandom_range(99) >= 18);

  always @(posedge clk_i)
    if (out_valid_o && out_ready_i) sb.check_pixel(pixel_out_o, frame_last_o);

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  // Offers one item and returns once it has been transferred. Valid is dropped
  // only for the random idle cycles that precede an item.
  task automatic send_item(logic cmd, logic [PIX_W-1:0] pix);
    while (!calm && $urandom_range(99) < 18) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(cmd, pix);
    sent_items++;
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= COEF_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Holds input back until every due pixel has come out, then lets the block settle
  // in case it is still busy on an item with no result.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic program_frame(int unsigned w, int unsigned h, int unsigned r,
                               int unsigned c0, int unsigned c1, int unsigned c2,
                               int unsigned c3, int unsigned c4);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    write_reg(REG_COEF_CENTER, c0);
    write_reg(REG_COEF_1, c1);
    write_reg(REG_COEF_2, c2);
    write_reg(REG_COEF_3, c3);
    write_reg(REG_COEF_4, c4);
  endtask

  // Streams one whole frame and then drains it. Stray drains during the pixel
  // phase and stray pixels during the drain phase must both be ignored. With
  // pause set, input stops once mid-frame until all due pixels are out.
  task automatic run_frame(int pix_mode, bit noise, bit pause);
    int unsigned w, h, r, total, lag;
    logic [PIX_W-1:0] pix;
    sb.geometry(w, h, r, total, lag);
    for (int unsigned i = 0; i < total; i++) begin
      if (noise && $urandom_range(99) < 8) send_item(CMD_DRAIN, PIX_W'($urandom));
      case (pix_mode)
        0:       pix = 8'd0;
        1:       pix = 8'd255;
        2:       pix = (i % 2) ? 8'd255 : 8'd0;
        default: pix = PIX_W'($urandom);
      endcase
      send_item(CMD_PIXEL, pix);
      if (pause && i == total / 2) wait_drained();
    end
    while (sb.in_cnt != 0) begin
      if (noise && $urandom_range(99) < 8) send_item(CMD_PIXEL, PIX_W'($urandom));
      send_item(CMD_DRAIN, PIX_W'($urandom));
    end
    wait_drained();
  endtask

  function automatic int unsigned pick_weight();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 65536;
      2:       return $urandom_range(65536);
      default: return $urandom_range(24000);
    endcase
  endfunction

  initial begin
    int unsigned w, h, r;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // A short frame with the reset weights, then identity on a single pixel.
    program_frame(3, 3, 2, 26386, 16004, 3571, 0, 0);
    run_frame(3, 1'b0, 1'b0);
    program_frame(1, 1, 0, 65536, 0, 0, 0, 0);
    run_frame(1, 1'b0, 1'b0);
    run_frame(0, 1'b0, 1'b0);
    // Full weights at the widest radius: both sums saturate on bright input.
    program_frame(3, 2, 4, 65536, 65536, 65536, 65536, 65536);
    run_frame(1, 1'b0, 1'b0);
    run_frame(2, 1'b1, 1'b0);
    // Zero weights everywhere, and a radius wider than the frame.
    program_frame(2, 3, 4, 0, 0, 0, 0, 0);
    run_frame(3, 1'b1, 1'b0);
    // Out-of-range register values are clamped by the block.
    program_frame(0, 0, 7, 40000, 12000, 0, 65536, 1);
    run_frame(3, 1'b1, 1'b0);

    // Random frames, mostly small, with a stretch where nobody idles.
    for (int f = 0; sent_items < 1250; f++) begin
      calm = (f >= 10 && f < 16);
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
      h = $urandom_range(10, 1);
      r = $urandom_range(5) == 0 ? $urandom_range(7, 5) : $urandom_range(4);
      program_frame(w, h, r, pick_weight(), pick_weight(), pick_weight(),
                    pick_weight(), pick_weight());
      run_frame(3, $urandom_range(2) == 0, f == 3);
    end
    calm = 1'b0;

    wait_drained();
    if (sb.errors == 0 && sb.due_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
